/* design/chirp_dedrift_block_decimator_top_assert.svh */
// Assertion macros for the dechirp decimator.
// Included by the top level; no other dependencies.
`ifndef CHIRP_DEDRIFT_BLOCK_DECIMATOR_TOP_ASSERT_SVH
`define CHIRP_DEDRIFT_BLOCK_DECIMATOR_TOP_ASSERT_SVH

// same-cycle implication, disabled during reset
`define CDBD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define CDBD_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/cdbd_pkg.sv */
// Shared types, constants and rounding helpers for the dechirp decimator.
// No dependencies.
package cdbd_pkg;

  localparam int MAX_BLOCK_DEF   = 4096;
  localparam int SAMPLE_BITS_DEF = 16;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int ROT_W      = 32;
  localparam int BLK_LEN_W  = 13;
  localparam int GAIN_W     = 16;
  localparam int LIMIT_W    = 16;
  localparam int SUM_W      = 48;
  localparam int OUT_W      = 32;

  // register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_INIT_STEP_RE = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_INIT_STEP_IM = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_STEP_TURN_RE = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_STEP_TURN_IM = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_BLOCK_LENGTH = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_OUTPUT_GAIN  = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_OUTPUT_LIMIT = 3'd6;

  localparam logic signed [ROT_W-1:0] ONE_Q30  = 32'sh4000_0000;
  localparam logic signed [ROT_W-1:0] ZERO_Q30 = 32'sh0000_0000;

  localparam logic signed [SUM_W-1:0] SUM_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [SUM_W-1:0] SUM_MIN = 48'sh8000_0000_0000;
  localparam logic signed [OUT_W-1:0] OUT_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [OUT_W-1:0] OUT_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic signed [ROT_W-1:0] init_step_re;
    logic signed [ROT_W-1:0] init_step_im;
    logic signed [ROT_W-1:0] step_turn_re;
    logic signed [ROT_W-1:0] step_turn_im;
    logic [BLK_LEN_W-1:0]    block_length;
    logic [GAIN_W-1:0]       output_gain;
    logic [LIMIT_W-1:0]      output_limit;
  } cfg_t;

  // controller to datapath
  typedef struct packed {
    logic load;     // word accepted: capture sample
    logic restart;  // reset rotator, step and sum
    logic mul;      // form all products
    logic acc;      // fold products into sum, rotator and step
    logic end_blk;  // this word closes a block
    logic emit;     // closed block yields a result
  } dp_cmd_t;

  // round a Q2.30 product pair back to Q2.30, saturate to 32 bits
  function automatic logic signed [ROT_W-1:0] rnd_sat_q30(input logic signed [64:0] s);
    logic signed [65:0] t;
    logic signed [35:0] q;
    t = 66'(s) + 66'sd536870912;
    q = 36'(t >>> 30);
    if (q > 36'(OUT_MAX)) begin
      return OUT_MAX;
    end else if (q < 36'(OUT_MIN)) begin
      return OUT_MIN;
    end
    return 32'(q);
  endfunction

  // saturating accumulator limit
  function automatic logic signed [SUM_W-1:0] sat_sum(input logic signed [SUM_W:0] s);
    if (s > 49'(SUM_MAX)) begin
      return SUM_MAX;
    end else if (s < 49'(SUM_MIN)) begin
      return SUM_MIN;
    end
    return 48'(s);
  endfunction

  // round sum*gain by 2^32, saturate to 32 bits
  function automatic logic signed [OUT_W-1:0] rnd_sat_out(input logic signed [64:0] p);
    logic signed [65:0] t;
    logic signed [33:0] q;
    t = 66'(p) + 66'sd2147483648;
    q = 34'(t >>> 32);
    if (q > 34'(OUT_MAX)) begin
      return OUT_MAX;
    end else if (q < 34'(OUT_MIN)) begin
      return OUT_MIN;
    end
    return 32'(q);
  endfunction

endpackage

/* design/cdbd_cfg_regs.sv */
// Configuration register file for the dechirp decimator.
// Depends on cdbd_pkg.
module cdbd_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [cdbd_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [cdbd_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output cdbd_pkg::cfg_t                  cfg
);
  import cdbd_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.init_step_re <= ONE_Q30;
      cfg_r.init_step_im <= ZERO_Q30;
      cfg_r.step_turn_re <= ONE_Q30;
      cfg_r.step_turn_im <= ZERO_Q30;
      cfg_r.block_length <= 13'd1;
      cfg_r.output_gain  <= 16'hFFFF;
      cfg_r.output_limit <= 16'hFFFF;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_INIT_STEP_RE: cfg_r.init_step_re <= $signed(cfg_wdata);
        REG_INIT_STEP_IM: cfg_r.init_step_im <= $signed(cfg_wdata);
        REG_STEP_TURN_RE: cfg_r.step_turn_re <= $signed(cfg_wdata);
        REG_STEP_TURN_IM: cfg_r.step_turn_im <= $signed(cfg_wdata);
        REG_BLOCK_LENGTH: cfg_r.block_length <= cfg_wdata[BLK_LEN_W-1:0];
        REG_OUTPUT_GAIN:  cfg_r.output_gain  <= cfg_wdata[GAIN_W-1:0];
        REG_OUTPUT_LIMIT: cfg_r.output_limit <= cfg_wdata[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

/* design/cdbd_ctrl.sv */
// Sequencer for the dechirp decimator: handshake, block position and result count.
// Depends on cdbd_pkg.
module cdbd_ctrl #(
  parameter int MAX_BLOCK = cdbd_pkg::MAX_BLOCK_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic                           start_channel,
  input  logic [cdbd_pkg::BLK_LEN_W-1:0] block_length,
  input  logic [cdbd_pkg::LIMIT_W-1:0]   output_limit,
  input  logic                           dump_busy,
  output cdbd_pkg::dp_cmd_t              cmd
);
  import cdbd_pkg::*;

  localparam int PB = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;
  localparam int LW = (PB + 1 > BLK_LEN_W) ? PB + 1 : BLK_LEN_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_ACC  = 2'd2;

  logic [1:0]         state_r, state_nxt;
  logic [PB-1:0]      pos_r, pos_nxt;
  logic [LIMIT_W-1:0] given_r, given_nxt;
  logic [PB:0]        pos_inc;
  logic [LW-1:0]      len_eff;
  logic               end_blk, emit, accept;

  always_comb begin
    if (block_length == '0) begin
      len_eff = LW'(1);
    end else if (LW'(block_length) > LW'(MAX_BLOCK)) begin
      len_eff = LW'(MAX_BLOCK);
    end else begin
      len_eff = LW'(block_length);
    end
  end

  assign pos_inc = (PB + 1)'(pos_r) + (PB + 1)'(1);
  assign end_blk = (state_r == S_ACC) && (LW'(pos_inc) >= len_eff);
  assign emit    = end_blk && (given_r < output_limit);

  // take a new word while idle or while folding the last one, unless a result is queued
  assign in_tready = ((state_r == S_IDLE) || (state_r == S_ACC)) && !dump_busy && !emit;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    state_nxt = state_r;
    pos_nxt   = pos_r;
    given_nxt = given_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        state_nxt = S_ACC;
      end
      S_ACC: begin
        state_nxt = accept ? S_MUL : S_IDLE;
        pos_nxt   = end_blk ? '0 : PB'(pos_inc);
        if (emit) begin
          given_nxt = given_r + LIMIT_W'(1);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    // restart overrides the position and result count of the previous word's fold
    if (accept && start_channel) begin
      pos_nxt   = '0;
      given_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pos_r   <= '0;
      given_r <= '0;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
      given_r <= given_nxt;
    end
  end

  always_comb begin
    cmd.load    = accept;
    cmd.restart = accept && start_channel;
    cmd.mul     = (state_r == S_MUL);
    cmd.acc     = (state_r == S_ACC);
    cmd.end_blk = end_blk;
    cmd.emit    = emit;
  end

endmodule

/* design/cdbd_datapath.sv */
// Datapath of the dechirp decimator: mixer products, rotator and step recurrences,
// block accumulator and the scale/round/saturate output pipe. Depends on cdbd_pkg.
module cdbd_datapath #(
  parameter int SAMPLE_BITS = cdbd_pkg::SAMPLE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  cdbd_pkg::dp_cmd_t                 cmd,
  input  cdbd_pkg::cfg_t                    cfg,
  input  logic signed [SAMPLE_BITS-1:0]     sample_re,
  input  logic signed [SAMPLE_BITS-1:0]     sample_im,
  output logic                              dump_busy,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic signed [cdbd_pkg::OUT_W-1:0] out_re,
  output logic signed [cdbd_pkg::OUT_W-1:0] out_im
);
  import cdbd_pkg::*;

  localparam int MW = SAMPLE_BITS + ROT_W;  // sample x rotator
  localparam int PW = MW + 1;               // sum of two of those
  localparam int RW = 2 * ROT_W;            // rotator x step

  logic signed [SAMPLE_BITS-1:0] smp_re_r, smp_im_r;
  logic signed [ROT_W-1:0]       rot_re_r, rot_im_r, step_re_r, step_im_r;
  logic signed [SUM_W-1:0]       sum_re_r, sum_im_r;

  // registered products
  logic signed [MW-1:0]          m_sr_rr_r, m_si_ri_r, m_sr_ri_r, m_si_rr_r;
  logic signed [2*ROT_W-1:0]     r_rr_r, r_ii_r, r_ri_r, r_ir_r;
  logic signed [2*ROT_W-1:0]     s_rr_r, s_ii_r, s_ri_r, s_ir_r;

  logic signed [PW-1:0]          mix_re, mix_im;
  logic signed [SUM_W-1:0]       sum_re_nxt, sum_im_nxt;

  // output pipe
  logic signed [SUM_W-1:0]       dump_re_r, dump_im_r;
  logic                          dump_v_r;
  logic signed [64:0]            scl_re_r, scl_im_r;
  logic                          scl_v_r;
  logic signed [OUT_W-1:0]       out_re_r, out_im_r;
  logic                          out_v_r;
  logic                          scl_move, dump_move;

  // round to Q.16: add 2^13, floor-shift by 14
  assign mix_re = (PW'(m_sr_rr_r) - PW'(m_si_ri_r) + PW'(8192)) >>> 14;
  assign mix_im = (PW'(m_sr_ri_r) + PW'(m_si_rr_r) + PW'(8192)) >>> 14;

  assign sum_re_nxt = sat_sum(49'(sum_re_r) + 49'(mix_re));
  assign sum_im_nxt = sat_sum(49'(sum_im_r) + 49'(mix_im));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      smp_re_r <= sample_re;
      smp_im_r <= sample_im;
    end
    if (cmd.mul) begin
      m_sr_rr_r <= MW'(smp_re_r) * MW'(rot_re_r);
      m_si_ri_r <= MW'(smp_im_r) * MW'(rot_im_r);
      m_sr_ri_r <= MW'(smp_re_r) * MW'(rot_im_r);
      m_si_rr_r <= MW'(smp_im_r) * MW'(rot_re_r);
      r_rr_r    <= RW'(rot_re_r) * RW'(step_re_r);
      r_ii_r    <= RW'(rot_im_r) * RW'(step_im_r);
      r_ri_r    <= RW'(rot_re_r) * RW'(step_im_r);
      r_ir_r    <= RW'(rot_im_r) * RW'(step_re_r);
      s_rr_r    <= RW'(step_re_r) * RW'(cfg.step_turn_re);
      s_ii_r    <= RW'(step_im_r) * RW'(cfg.step_turn_im);
      s_ri_r    <= RW'(step_re_r) * RW'(cfg.step_turn_im);
      s_ir_r    <= RW'(step_im_r) * RW'(cfg.step_turn_re);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rot_re_r  <= ONE_Q30;
      rot_im_r  <= ZERO_Q30;
      step_re_r <= ONE_Q30;
      step_im_r <= ZERO_Q30;
      sum_re_r  <= '0;
      sum_im_r  <= '0;
    end else begin
      if (cmd.acc) begin
        rot_re_r  <= rnd_sat_q30(65'(r_rr_r) - 65'(r_ii_r));
        rot_im_r  <= rnd_sat_q30(65'(r_ri_r) + 65'(r_ir_r));
        step_re_r <= rnd_sat_q30(65'(s_rr_r) - 65'(s_ii_r));
        step_im_r <= rnd_sat_q30(65'(s_ri_r) + 65'(s_ir_r));
        sum_re_r  <= cmd.end_blk ? '0 : sum_re_nxt;
        sum_im_r  <= cmd.end_blk ? '0 : sum_im_nxt;
      end
      // restart overrides the fold of the previous word
      if (cmd.restart) begin
        rot_re_r  <= ONE_Q30;
        rot_im_r  <= ZERO_Q30;
        step_re_r <= cfg.init_step_re;
        step_im_r <= cfg.init_step_im;
        sum_re_r  <= '0;
        sum_im_r  <= '0;
      end
    end
  end

  // output pipe: dump -> scale product -> rounded result
  assign scl_move  = scl_v_r && (!out_v_r || out_tready);
  assign dump_move = dump_v_r && (!scl_v_r || scl_move);

  always_ff @(posedge clk) begin
    if (cmd.acc && cmd.emit) begin
      dump_re_r <= sum_re_nxt;
      dump_im_r <= sum_im_nxt;
    end
    if (dump_move) begin
      scl_re_r <= 65'(dump_re_r) * 65'($signed({1'b0, cfg.output_gain}));
      scl_im_r <= 65'(dump_im_r) * 65'($signed({1'b0, cfg.output_gain}));
    end
    if (scl_move) begin
      out_re_r <= rnd_sat_out(scl_re_r);
      out_im_r <= rnd_sat_out(scl_im_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dump_v_r <= 1'b0;
      scl_v_r  <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      // dump fills only while empty, so set and drain never collide
      if (cmd.acc && cmd.emit) begin
        dump_v_r <= 1'b1;
      end else if (dump_move) begin
        dump_v_r <= 1'b0;
      end
      if (dump_move) begin
        scl_v_r <= 1'b1;
      end else if (scl_move) begin
        scl_v_r <= 1'b0;
      end
      if (scl_move) begin
        out_v_r <= 1'b1;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  assign dump_busy  = dump_v_r;
  assign out_tvalid = out_v_r;
  assign out_re     = out_re_r;
  assign out_im     = out_im_r;

endmodule

/* design/chirp_dedrift_block_decimator_top.sv */
// Dechirp mixer with integrate-and-dump decimation, top level.
// Channels: in_* takes one complex sample per word, in_tuser[0] = start_channel
// (restart rotator, step, sum and counters before this sample). out_* gives one
// complex block result per word. cfg_* writes registers by index, one per cycle.
// Each sample passes a multiply state and a fold state of the rotator recurrence;
// the next word is taken during the fold state.
// When a sample closes a block with a result, the next word waits until the
// result leaves the dump register for the scale stage.
// A block's last sample reaches out_tvalid through the multiply, the fold
// into the dump register, the scale stage and the round/saturate stage.
// Reset (rst_n low, synchronous): registers return to defaults, rotator to one,
// step to the default first step, sums and counters clear, pipes empty.
// Receiver stall: the result waits in the output register and a second one in the
// scale stage; in_tready stays low while a result sits in the dump register, so a
// third result stops the input until the receiver takes a word.
// Depends on cdbd_pkg, cdbd_cfg_regs, cdbd_ctrl, cdbd_datapath and the
// assertion macro header.
module chirp_dedrift_block_decimator_top #(
  parameter int MAX_BLOCK   = cdbd_pkg::MAX_BLOCK_DEF,
  parameter int SAMPLE_BITS = cdbd_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  // sample_re [SAMPLE_BITS-1:0], sample_im above it, zero pad to bytes
  input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]     in_tdata,
  // start_channel
  input  logic [0:0]                             in_tuser,
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  // out_re [31:0], out_im [63:32]
  output logic [2*cdbd_pkg::OUT_W-1:0]           out_tdata,
  input  logic                                   cfg_we,
  input  logic [cdbd_pkg::CFG_ADDR_W-1:0]        cfg_addr,
  input  logic [cdbd_pkg::CFG_DATA_W-1:0]        cfg_wdata
);
  import cdbd_pkg::*;

  cfg_t                         cfg;
  dp_cmd_t                      dp_cmd;
  logic                         dump_busy;
  logic signed [OUT_W-1:0]      out_re, out_im;

  cdbd_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  cdbd_ctrl #(
    .MAX_BLOCK (MAX_BLOCK)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .start_channel (in_tuser[0]),
    .block_length  (cfg.block_length),
    .output_limit  (cfg.output_limit),
    .dump_busy     (dump_busy),
    .cmd           (dp_cmd)
  );

  cdbd_datapath #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (dp_cmd),
    .cfg        (cfg),
    .sample_re  ($signed(in_tdata[SAMPLE_BITS-1:0])),
    .sample_im  ($signed(in_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS])),
    .dump_busy  (dump_busy),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_re     (out_re),
    .out_im     (out_im)
  );

  assign out_tdata = {out_im, out_re};

  `include "chirp_dedrift_block_decimator_top_assert.svh"

  `CDBD_ASSERT_NXT(a_accept_then_busy, clk, rst_n, in_tvalid && in_tready, !in_tready, "word accepted while previous one still multiplying")
  `CDBD_ASSERT_NXT(a_emit_fills_dump, clk, rst_n, dp_cmd.emit, dump_busy, "block result did not reach the dump register")
  `CDBD_ASSERT_IMP(a_dump_blocks_input, clk, rst_n, dump_busy, !in_tready, "input taken while a block result waits in the dump register")

endmodule
